// ===== src/bfra_pkg.sv =====
`timescale 1ns / 1ps
package bfra_pkg;

  localparam int unsigned HeapSlots = 256;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_TOTAL = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_Q_FULL   = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;

  typedef struct packed {
    logic [7:0] start;
    logic [8:0] size;
  } span_t;

  typedef struct packed {
    logic [7:0]  start;
    logic [8:0]  size;
    logic [47:0] frame;
  } stale_t;

  // controller to datapath
  typedef struct packed {
    logic       latch_req;
    logic       set_status;
    logic [2:0] status;
    logic       q_push;
    logic       q_read;
    logic       q_pop;
    logic       scan_clear;
    logic       scan_rd;
    logic       alloc_apply;
    logic       ret_apply;
    logic       load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       cnt_zero;
    logic       cnt_gt_total;
    logic       free_bad;
    logic       q_full;
    logic       q_empty;
    logic       frame_gt;
    logic       scan_last;
    logic       best_found;
  } stat_t;

endpackage

// ===== src/best_fit_range_allocator.sv =====
`timescale 1ns / 1ps
// channel | handshake                | word
// in      | in_valid_i / in_ready_o  | req_type_i slot_count_i block_start_i frame_number_i
// out     | out_valid_o / out_ready_i| status_o alloc_start_o free_total_o released_blocks_o
// cfg     | cfg_we_i                 | cfg_wdata_i (heap_slots_in_use)
//
// free and rejected requests skip the table; an allocate makes one table pass and a release
// one per retired block, until the queue empties or a newer tag stops it:
// each table pass reads one entry a cycle through the table memory's read port
// reset gives one free block over the whole heap and an empty stale queue, no clearing pass
// a result waits in the output register; the next word is taken while it stalls
module best_fit_range_allocator #(
  parameter int unsigned MAX_FREE_BLOCKS = 128,
  parameter int unsigned STALE_DEPTH     = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [8:0]  slot_count_i,
  input  logic [7:0]  block_start_i,
  input  logic [47:0] frame_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  alloc_start_o,
  output logic [8:0]  free_total_o,
  output logic [6:0]  released_blocks_o
);
  import bfra_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: decode, table scans, release loop, result hand-off
  bfra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // free table, stale queue, best-fit and coalescing compares
  bfra_dp #(
    .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS),
    .STALE_DEPTH     (STALE_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_type_i        (req_type_i),
    .slot_count_i      (slot_count_i),
    .block_start_i     (block_start_i),
    .frame_number_i    (frame_number_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .status_o          (status_o),
    .alloc_start_o     (alloc_start_o),
    .free_total_o      (free_total_o),
    .released_blocks_o (released_blocks_o)
  );

endmodule

// ===== src/bfra_dp.sv =====
`timescale 1ns / 1ps
module bfra_dp #(
  parameter int unsigned MAX_FREE_BLOCKS = 128,
  parameter int unsigned STALE_DEPTH     = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [8:0]          cfg_wdata_i,
  input  logic [1:0]          req_type_i,
  input  logic [8:0]          slot_count_i,
  input  logic [7:0]          block_start_i,
  input  logic [47:0]         frame_number_i,
  input  bfra_pkg::cmd_t      cmd_i,
  output bfra_pkg::stat_t     stat_o,
  output logic [2:0]          status_o,
  output logic [7:0]          alloc_start_o,
  output logic [8:0]          free_total_o,
  output logic [6:0]          released_blocks_o
);
  import bfra_pkg::*;

  localparam int unsigned TW = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;
  localparam int unsigned QW = (STALE_DEPTH > 1) ? $clog2(STALE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STALE_DEPTH + 1);
  localparam logic [TW-1:0] TLast = TW'(MAX_FREE_BLOCKS - 1);
  localparam logic [QW-1:0] QLast = QW'(STALE_DEPTH - 1);
  localparam logic [CW-1:0] QFull = CW'(STALE_DEPTH);

  span_t  tbl_mem [MAX_FREE_BLOCKS];
  stale_t q_mem   [STALE_DEPTH];
  logic [MAX_FREE_BLOCKS-1:0] valid_q;
  logic e0_init_q;

  logic [8:0]  heap_n_q, total_q;
  logic [QW-1:0] head_q, tail_q;
  logic [CW-1:0] qcnt_q;

  logic [1:0]  rtype_q;
  logic [8:0]  rcnt_q;
  logic [7:0]  rstart_q;
  logic [47:0] rframe_q;
  logic [2:0]  status_q;
  logic [7:0]  astart_q;
  logic [6:0]  rel_q;
  stale_t      qd_q;

  logic [TW-1:0] scan_cnt_q, rd_idx_q;
  logic          rd_vld_q, rd_val_q;
  span_t         rd_ent_q;

  logic          best_found_q;
  logic [TW-1:0] best_idx_q;
  logic [7:0]    best_start_q;
  logic [8:0]    best_size_q;
  logic          ovl_q, prev_found_q, next_found_q, hole_found_q;
  logic [TW-1:0] prev_idx_q, next_idx_q, hole_idx_q;
  logic [7:0]    prev_start_q;
  logic [8:0]    prev_size_q, next_size_q;

  logic [2:0]  status_oq;
  logic [7:0]  astart_oq;
  logic [8:0]  total_oq;
  logic [6:0]  rel_oq;

  logic [9:0] e_end, r_end;
  logic       better, ret_ok;
  logic       wr_en;
  logic [TW-1:0] wr_addr;
  span_t      wr_data;
  logic [8:0] cfg_n;
  logic [8:0] merged;

  assign e_end  = {2'b0, rd_ent_q.start} + {1'b0, rd_ent_q.size};
  assign r_end  = {2'b0, qd_q.start} + {1'b0, qd_q.size};
  assign better = rd_val_q && (rd_ent_q.size >= rcnt_q) &&
                  (!best_found_q || rd_ent_q.size < best_size_q ||
                   (rd_ent_q.size == best_size_q && rd_ent_q.start < best_start_q));
  assign ret_ok = !ovl_q && (prev_found_q || next_found_q || hole_found_q);
  assign merged = prev_size_q + qd_q.size + (next_found_q ? next_size_q : 9'd0);

  always_comb begin
    if (cfg_wdata_i == 9'd0) begin
      cfg_n = 9'd1;
    end else if ({23'd0, cfg_wdata_i} > HeapSlots) begin
      cfg_n = 9'(HeapSlots);
    end else begin
      cfg_n = cfg_wdata_i;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx_q;
    wr_data = '{start: 8'(best_start_q + rcnt_q[7:0]), size: best_size_q - rcnt_q};
    if (cmd_i.alloc_apply && best_found_q) begin
      wr_en = 1'b1;
    end else if (cmd_i.ret_apply && ret_ok) begin
      wr_en = 1'b1;
      if (prev_found_q) begin
        wr_addr = prev_idx_q;
        wr_data = '{start: prev_start_q, size: merged};
      end else if (next_found_q) begin
        wr_addr = next_idx_q;
        wr_data = '{start: qd_q.start, size: next_size_q + qd_q.size};
      end else begin
        wr_addr = hole_idx_q;
        wr_data = '{start: qd_q.start, size: qd_q.size};
      end
    end
  end

  // table and queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (scan_cnt_q == '0 && e0_init_q) begin
      rd_ent_q <= '{start: 8'd0, size: heap_n_q};
    end else begin
      rd_ent_q <= tbl_mem[scan_cnt_q];
    end
    rd_val_q <= valid_q[scan_cnt_q];
    rd_idx_q <= scan_cnt_q;
    if (cmd_i.q_push) begin
      q_mem[tail_q] <= '{start: rstart_q, size: rcnt_q, frame: rframe_q};
    end
    if (cmd_i.q_read) begin
      qd_q <= q_mem[head_q];
    end
  end

  // request, accumulators and output words
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      rtype_q  <= req_type_i;
      rcnt_q   <= slot_count_i;
      rstart_q <= block_start_i;
      rframe_q <= frame_number_i;
    end
    if (cmd_i.scan_clear) begin
      best_found_q <= 1'b0;
      ovl_q        <= 1'b0;
      prev_found_q <= 1'b0;
      next_found_q <= 1'b0;
      hole_found_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (better) begin
        best_found_q <= 1'b1;
        best_idx_q   <= rd_idx_q;
        best_start_q <= rd_ent_q.start;
        best_size_q  <= rd_ent_q.size;
      end
      if (!rd_val_q) begin
        if (!hole_found_q) begin
          hole_found_q <= 1'b1;
          hole_idx_q   <= rd_idx_q;
        end
      end else begin
        if ({2'b0, rd_ent_q.start} < r_end && {2'b0, qd_q.start} < e_end) begin
          ovl_q <= 1'b1;
        end
        if (e_end == {2'b0, qd_q.start}) begin
          prev_found_q <= 1'b1;
          prev_idx_q   <= rd_idx_q;
          prev_start_q <= rd_ent_q.start;
          prev_size_q  <= rd_ent_q.size;
        end
        if ({2'b0, rd_ent_q.start} == r_end) begin
          next_found_q <= 1'b1;
          next_idx_q   <= rd_idx_q;
          next_size_q  <= rd_ent_q.size;
        end
      end
    end
    if (cmd_i.load_out) begin
      status_oq <= status_q;
      astart_oq <= astart_q;
      total_oq  <= total_q;
      rel_oq    <= rel_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= MAX_FREE_BLOCKS'(1);
      e0_init_q  <= 1'b1;
      heap_n_q   <= 9'(HeapSlots);
      total_q    <= 9'(HeapSlots);
      head_q     <= '0;
      tail_q     <= '0;
      qcnt_q     <= '0;
      scan_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      status_q   <= ST_OK;
      astart_q   <= '0;
      rel_q      <= '0;
    end else if (cfg_we_i) begin
      valid_q   <= MAX_FREE_BLOCKS'(1);
      e0_init_q <= 1'b1;
      heap_n_q  <= cfg_n;
      total_q   <= cfg_n;
      head_q    <= '0;
      tail_q    <= '0;
      qcnt_q    <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.scan_clear) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      if (cmd_i.latch_req) begin
        status_q <= ST_OK;
        astart_q <= '0;
        rel_q    <= '0;
      end
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (wr_en && wr_addr == '0) begin
        e0_init_q <= 1'b0;
      end
      if (cmd_i.alloc_apply) begin
        if (best_found_q) begin
          astart_q <= best_start_q;
          total_q  <= total_q - rcnt_q;
          if (best_size_q == rcnt_q) begin
            valid_q[best_idx_q] <= 1'b0;
          end
        end else begin
          status_q <= ST_NO_FIT;
        end
      end
      if (cmd_i.ret_apply && ret_ok) begin
        total_q <= total_q + qd_q.size;
        if (rel_q != 7'd127) begin
          rel_q <= rel_q + 7'd1;
        end
        if (prev_found_q) begin
          if (next_found_q) begin
            valid_q[next_idx_q] <= 1'b0;
          end
        end else if (!next_found_q) begin
          valid_q[hole_idx_q] <= 1'b1;
        end
      end
      if (cmd_i.q_push) begin
        tail_q <= (tail_q == QLast) ? '0 : tail_q + 1'b1;
        qcnt_q <= qcnt_q + 1'b1;
      end
      if (cmd_i.q_pop) begin
        head_q <= (head_q == QLast) ? '0 : head_q + 1'b1;
        qcnt_q <= qcnt_q - 1'b1;
      end
    end
  end

  assign stat_o.req_type     = rtype_q;
  assign stat_o.cnt_zero     = (rcnt_q == 9'd0);
  assign stat_o.cnt_gt_total = (rcnt_q > total_q);
  assign stat_o.free_bad     = (rcnt_q == 9'd0) ||
                               (({2'b0, rstart_q} + {1'b0, rcnt_q}) > {1'b0, heap_n_q});
  assign stat_o.q_full       = (qcnt_q == QFull);
  assign stat_o.q_empty      = (qcnt_q == '0);
  assign stat_o.frame_gt     = (qd_q.frame > rframe_q);
  assign stat_o.scan_last    = (scan_cnt_q == TLast);
  assign stat_o.best_found   = best_found_q;

  assign status_o          = status_oq;
  assign alloc_start_o     = astart_oq;
  assign free_total_o      = total_oq;
  assign released_blocks_o = rel_oq;

endmodule

// ===== src/bfra_ctrl.sv =====
`timescale 1ns / 1ps
module bfra_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  bfra_pkg::stat_t stat_i,
  output bfra_pkg::cmd_t  cmd_o
);
  import bfra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_REL_CHK, S_REL_HEAD, S_SCAN, S_DRAIN, S_APPLY, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   is_alloc_q, is_alloc_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    is_alloc_d  = is_alloc_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (stat_i.req_type)
          REQ_ALLOC: begin
            if (stat_i.cnt_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BAD;
            end else if (stat_i.cnt_gt_total) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NO_TOTAL;
            end else begin
              cmd_o.scan_clear = 1'b1;
              is_alloc_d = 1'b1;
              state_d = S_SCAN;
            end
          end
          REQ_FREE: begin
            if (stat_i.free_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BAD;
            end else if (stat_i.q_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_Q_FULL;
            end else begin
              cmd_o.q_push = 1'b1;
            end
          end
          REQ_RELEASE: begin
            state_d = S_REL_CHK;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_REL_CHK: begin
        if (stat_i.q_empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.q_read = 1'b1;
          state_d = S_REL_HEAD;
        end
      end
      S_REL_HEAD: begin
        if (stat_i.frame_gt) begin
          state_d = S_DONE;
        end else begin
          cmd_o.scan_clear = 1'b1;
          is_alloc_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (is_alloc_q) begin
          cmd_o.alloc_apply = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.ret_apply = 1'b1;
          cmd_o.q_pop     = 1'b1;
          state_d = S_REL_CHK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      is_alloc_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      is_alloc_q  <= is_alloc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== test/tb_best_fit_range_allocator.sv =====
`timescale 1ns / 1ps
module tb_best_fit_range_allocator;
  import bfra_pkg::*;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned SettleCycles = 20000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  count;
    logic [7:0]  start;
    logic [47:0] frame;
  } req_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] astart;
    logic [8:0] total;
    logic [6:0] released;
  } rsp_word_t;

  typedef struct {
    bit          used;
    int unsigned start;
    int unsigned size;
  } blk_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [8:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  req_type_i;
  logic [8:0]  slot_count_i;
  logic [7:0]  block_start_i;
  logic [47:0] frame_number_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [7:0]  alloc_start_o;
  logic [8:0]  free_total_o;
  logic [6:0]  released_blocks_o;

  best_fit_range_allocator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .req_type_i, .slot_count_i, .block_start_i,
    .frame_number_i, .out_valid_o, .out_ready_i, .status_o, .alloc_start_o,
    .free_total_o, .released_blocks_o
  );

  // shadow copy of the heap
  blk_t        heap_tbl[TableDepth];
  int unsigned heap_free;
  int unsigned heap_size;
  int unsigned stale_start[QueueDepth];
  int unsigned stale_size[QueueDepth];
  logic [47:0] stale_frame[QueueDepth];
  int unsigned q_head, q_tail, q_count;

  req_word_t pending_q[$];
  rsp_word_t expected_rsp_q[$];
  int unsigned errors;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off;
  bit          in_fire;
  logic [47:0] frame_now;

  // reinit the shadow heap as one free block
  task automatic heap_init(input int unsigned n);
    for (int i = 0; i < TableDepth; i++) heap_tbl[i] = '{0, 0, 0};
    heap_tbl[0] = '{1, 0, n};
    heap_free = n;
    heap_size = n;
    q_head = 0;
    q_tail = 0;
    q_count = 0;
  endtask

  // merge a retired span into the table, 1 when taken
  function automatic bit merge_span(input int unsigned off, input int unsigned n);
    int prev, next, hole;
    prev = -1;
    next = -1;
    hole = -1;
    for (int i = 0; i < TableDepth; i++) begin
      if (!heap_tbl[i].used) begin
        if (hole < 0) hole = i;
        continue;
      end
      // double free overlaps an existing block
      if (heap_tbl[i].start < off + n && off < heap_tbl[i].start + heap_tbl[i].size)
        return 0;
      if (heap_tbl[i].start + heap_tbl[i].size == off) prev = i;
      if (heap_tbl[i].start == off + n) next = i;
    end
    if (prev >= 0) begin
      heap_tbl[prev].size += n;
      if (next >= 0) begin
        heap_tbl[prev].size += heap_tbl[next].size;
        heap_tbl[next].used = 0;
      end
    end else if (next >= 0) begin
      heap_tbl[next].start = off;
      heap_tbl[next].size += n;
    end else if (hole >= 0) begin
      heap_tbl[hole] = '{1, off, n};
    end else begin
      return 0; // table full
    end
    heap_free += n;
    return 1;
  endfunction

  // compute the response word of one request
  function automatic rsp_word_t heap_predict(input req_word_t r);
    rsp_word_t   o;
    int          best;
    int unsigned rel;
    o = '0;
    rel = 0;
    case (r.kind)
      REQ_ALLOC: begin
        if (r.count == 0) o.status = ST_BAD;
        else if (r.count > heap_free) o.status = ST_NO_TOTAL;
        else begin
          best = -1;
          for (int i = 0; i < TableDepth; i++) begin
            if (!heap_tbl[i].used || heap_tbl[i].size < r.count) continue;
            if (best < 0 || heap_tbl[i].size < heap_tbl[best].size ||
                (heap_tbl[i].size == heap_tbl[best].size &&
                 heap_tbl[i].start < heap_tbl[best].start))
              best = i;
          end
          if (best < 0) o.status = ST_NO_FIT;
          else begin
            o.astart = heap_tbl[best].start[7:0];
            heap_tbl[best].start += r.count;
            heap_tbl[best].size -= r.count;
            if (heap_tbl[best].size == 0) heap_tbl[best].used = 0;
            heap_free -= r.count;
          end
        end
      end
      REQ_FREE: begin
        if (r.count == 0 || r.start + r.count > heap_size) o.status = ST_BAD;
        else if (q_count >= QueueDepth) o.status = ST_Q_FULL;
        else begin
          stale_start[q_tail] = r.start;
          stale_size[q_tail] = r.count;
          stale_frame[q_tail] = r.frame;
          q_tail = (q_tail + 1) % QueueDepth;
          q_count++;
        end
      end
      REQ_RELEASE: begin
        // retire oldest first while the tag is not newer than the frame
        while (q_count > 0 && stale_frame[q_head] <= r.frame) begin
          if (merge_span(stale_start[q_head], stale_size[q_head]) && rel < 127) rel++;
          q_head = (q_head + 1) % QueueDepth;
          q_count--;
        end
      end
      default: ;
    endcase
    o.total = heap_free[8:0];
    o.released = rel[6:0];
    return o;
  endfunction

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // input handshake seen at the rising edge
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && in_ready_o;
  end

  // driver: words change on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
    end else if (in_valid_i && !in_fire) begin
      // hold the word until taken
    end else if (pending_q.size() != 0 && !hold_off &&
                 $urandom_range(99) >= send_idle_pct) begin
      req_word_t r;
      r = pending_q.pop_front();
      expected_rsp_q.push_back(heap_predict(r));
      words_sent++;
      in_valid_i <= 1;
      req_type_i <= r.kind;
      slot_count_i <= r.count;
      block_start_i <= r.start;
      frame_number_i <= r.frame;
    end else begin
      in_valid_i <= 0;
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: compare each response word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected word: status %0d", status_o);
        errors++;
      end else begin
        rsp_word_t e;
        e = expected_rsp_q.pop_front();
        words_checked++;
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o);
          errors++;
        end
        if (alloc_start_o !== e.astart) begin
          $error("alloc_start exp %0d got %0d", e.astart, alloc_start_o);
          errors++;
        end
        if (free_total_o !== e.total) begin
          $error("free_total exp %0d got %0d", e.total, free_total_o);
          errors++;
        end
        if (released_blocks_o !== e.released) begin
          $error("released_blocks exp %0d got %0d", e.released, released_blocks_o);
          errors++;
        end
      end
    end
  end

  task automatic push_req(input logic [1:0] k, input int unsigned c,
                          input int unsigned s, input logic [47:0] f);
    pending_q.push_back('{k, c[8:0], s[7:0], f});
  endtask

  // wait for every queued word to be sent and answered
  task automatic drain();
    while (pending_q.size() != 0 || expected_rsp_q.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write while the block sits idle
  task automatic write_heap_size(input logic [8:0] v);
    int unsigned n;
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    n = v;
    if (n < 1) n = 1;
    if (n > HeapSlots) n = HeapSlots;
    heap_init(n);
  endtask

  // mostly well-formed traffic: allocations, frees of real spans, releases
  task automatic random_phase(input int unsigned n_words);
    int unsigned pick, c, s;
    for (int i = 0; i < n_words; i++) begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        c = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 24);
        push_req(REQ_ALLOC, c, 0, 48'({$urandom, $urandom}));
      end else if (pick < 78) begin
        c = ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(1, 24);
        s = $urandom_range(255);
        frame_now += 48'($urandom_range(3));
        push_req(REQ_FREE, c, s,
                 ($urandom_range(19) == 0) ? 48'({$urandom, $urandom}) : frame_now);
      end else if (pick < 97) begin
        push_req(REQ_RELEASE, $urandom_range(511), $urandom_range(255),
                 ($urandom_range(9) == 0) ? 48'({$urandom, $urandom}) :
                 frame_now - 48'($urandom_range(4)));
      end else begin
        push_req(REQ_UNUSED, $urandom_range(511), $urandom_range(255),
                 48'({$urandom, $urandom}));
      end
    end
  endtask

  initial begin
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    hold_off = 0;
    frame_now = 0;
    send_idle_pct = 32;
    recv_idle_pct = 81;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = 0;
    in_valid_i = 0;
    out_ready_i = 0;
    req_type_i = 0;
    slot_count_i = 0;
    block_start_i = 0;
    frame_number_i = 0;
    heap_init(HeapSlots);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: extremes and each error path
    push_req(REQ_ALLOC, 0, 0, 0);                 // zero-size allocate
    push_req(REQ_ALLOC, 257, 0, 0);               // more than free total
    push_req(REQ_ALLOC, 16, 0, 0);
    push_req(REQ_ALLOC, 16, 0, 0);
    push_req(REQ_ALLOC, 224, 0, 0);               // heap now full
    push_req(REQ_FREE, 0, 3, 1);                  // zero-size free
    push_req(REQ_FREE, 2, 255, 1);                // past heap end
    push_req(REQ_FREE, 16, 0, 5);
    push_req(REQ_FREE, 1, 255, 48'hFFFF_FFFF_FFFF);
    push_req(REQ_FREE, 8, 16, 6);
    push_req(REQ_FREE, 8, 0, 6);                  // double free
    push_req(REQ_RELEASE, 0, 0, 4);               // nothing old enough
    push_req(REQ_RELEASE, 0, 0, 6);               // retires only the oldest span; a newer tag stops it
    push_req(REQ_ALLOC, 20, 0, 0);                // no block fits
    push_req(REQ_ALLOC, 8, 0, 0);
    push_req(REQ_RELEASE, 511, 255, 48'hFFFF_FFFF_FFFF);
    push_req(REQ_UNUSED, 511, 255, 48'hFFFF_FFFF_FFFF); // unknown type
    for (int i = 0; i < 65; i++) push_req(REQ_FREE, 1, i, 48'(i)); // queue full on the last
    push_req(REQ_RELEASE, 0, 0, 48'hFFFF_FFFF_FFFF);
    drain();

    // small heap
    write_heap_size(9'd0);
    push_req(REQ_ALLOC, 1, 0, 0);
    push_req(REQ_FREE, 1, 0, 0);
    push_req(REQ_FREE, 1, 1, 0);                  // out of range at size 1
    push_req(REQ_RELEASE, 0, 0, 0);
    random_phase(100);
    drain();

    write_heap_size(9'd511);                      // clamps to full heap
    frame_now = 0;
    random_phase(300);

    // pause the sender mid-phase until every result is back
    repeat (2000) @(posedge clk_i);
    hold_off = 1;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    hold_off = 0;
    drain();

    send_idle_pct = 81;
    recv_idle_pct = 32;
    write_heap_size(9'd100);
    random_phase(250);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_heap_size(9'd256);
    random_phase(250);
    drain();

    $display("sent %0d request words, checked %0d responses over five heap setups",
             words_sent, words_checked);
    $display("covered allocate, deferred free, release, errors and unknown type");
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
